@@ rtl/upp_pkg.sv @@
// ----------------------------------------------------------------------------
// upp_pkg
// shared types, codes and policy tables of the usb port power policy block
// ----------------------------------------------------------------------------
package upp_pkg;

	// port mode encoding
	typedef enum logic [2:0] {
		MODE_OFF = 3'd0,
		MODE_ON  = 3'd1,
		MODE_SDP = 3'd2,
		MODE_CDP = 3'd3,
		MODE_DCP = 3'd4
	} mode_t;

	// sleep state class
	typedef enum logic [1:0] {
		SX_S0  = 2'd0,
		SX_S3  = 2'd1,
		SX_S45 = 2'd2
	} sx_t;

	// sleep state codes
	localparam logic [3:0] ST_S3         = 4'd1;
	localparam logic [3:0] ST_S0_TO_S3   = 4'd2;
	localparam logic [3:0] ST_S4         = 4'd3;
	localparam logic [3:0] ST_S5_TO_DSX  = 4'd8;

	// configuration register indexes
	localparam logic [1:0] CFG_DBG_OVERRIDE = 2'd0;
	localparam logic [1:0] CFG_DBG_LEVEL    = 2'd1;
	localparam logic [1:0] CFG_DB_RELOAD    = 2'd2;

	localparam logic [7:0] DB_RELOAD_RST = 8'd40;
	localparam logic [6:0] BATT_MAX      = 7'd100;

	localparam int ITEM_W   = 18;
	localparam int RESULT_W = 19;
	localparam int TDATA_IN_W  = 24;
	localparam int TDATA_OUT_W = 24;

	// input item, first field in the highest bits
	typedef struct packed {
		logic       detect_level;
		logic       bios_wake_disable;
		logic       thermal_shutdown;
		logic [7:0] battery_level;
		logic       s45_dc_allow;
		logic       charge_enable;
		logic       ac_power;
		logic [3:0] sys_state;
	} item_t;

	// result item, first field in the highest bits
	typedef struct packed {
		logic       device_flag;
		logic       plain_power_drive;
		logic       ctl3_pin;
		logic       ctl1_pin;
		logic       aou_charge_pin;
		logic [7:0] power_type_byte;
		logic [2:0] plain_mode;
		logic [2:0] aou_mode;
	} result_t;

	typedef struct packed {
		logic       dbg_override;
		logic [6:0] dbg_level;
		logic [7:0] db_reload;
	} cfg_t;

	// final port modes handed from mode select to the pin state
	typedef struct packed {
		mode_t aou;
		mode_t plain;
		logic  wake_force;
	} mode_ctl_t;

	function automatic sx_t sx_class(input logic [3:0] st);
		sx_t r;
		if (st == ST_S3 || st == ST_S0_TO_S3) r = SX_S3;
		else if (st >= ST_S4 && st <= ST_S5_TO_DSX) r = SX_S45;
		else r = SX_S0;
		return r;
	endfunction

	// 3: 0-5, 2: 6-10, 1: 11-15, 0: 16 and up
	function automatic logic [1:0] batt_band(input logic [7:0] lvl);
		logic [1:0] r;
		if (lvl <= 8'd5) r = 2'd3;
		else if (lvl <= 8'd10) r = 2'd2;
		else if (lvl <= 8'd15) r = 2'd1;
		else r = 2'd0;
		return r;
	endfunction

	// row: bit0 on dc, bit1 charging disabled
	function automatic mode_t aou_tab(input logic [1:0] row, input sx_t sx);
		mode_t r;
		unique case (sx)
			SX_S0:   r = row[1] ? MODE_SDP : MODE_CDP;
			SX_S3:   r = row[1] ? MODE_SDP : MODE_DCP;
			SX_S45:  r = (row == 2'd0) ? MODE_DCP : MODE_OFF;
			default: r = MODE_OFF;
		endcase
		return r;
	endfunction

	function automatic mode_t plain_tab(input logic [1:0] row, input sx_t sx);
		mode_t r;
		unique case (sx)
			SX_S0, SX_S3: r = MODE_SDP;
			SX_S45:       r = (row == 2'd0) ? MODE_ON : MODE_OFF;
			default:      r = MODE_OFF;
		endcase
		return r;
	endfunction

	function automatic mode_t aou_bat(input sx_t sx, input logic [1:0] band);
		mode_t r;
		unique case (sx)
			SX_S0:   r = MODE_CDP;
			SX_S3:   r = (band[1] == 1'b0) ? MODE_DCP :
			             (band == 2'd2) ? MODE_SDP : MODE_OFF;
			SX_S45:  r = (band[1] == 1'b0) ? MODE_DCP : MODE_OFF;
			default: r = MODE_OFF;
		endcase
		return r;
	endfunction

	function automatic mode_t plain_bat(input sx_t sx, input logic [1:0] band);
		mode_t r;
		unique case (sx)
			SX_S0:   r = MODE_SDP;
			SX_S3:   r = (band == 2'd3) ? MODE_OFF : MODE_SDP;
			SX_S45:  r = MODE_OFF;
			default: r = MODE_OFF;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/upp_mode_sel.sv @@
// ----------------------------------------------------------------------------
// upp_mode_sel
// table lookup of both port modes with battery bands and overrides
// ----------------------------------------------------------------------------
module upp_mode_sel (
	input  upp_pkg::item_t     item,
	input  upp_pkg::cfg_t      cfg,
	output upp_pkg::mode_ctl_t ctl,
	output logic [7:0]         power_type
);

	upp_pkg::sx_t   sx;
	logic [1:0]     row;
	logic [7:0]     lvl;
	logic [1:0]     band;
	upp_pkg::mode_t aou_pol;
	upp_pkg::mode_t plain_pol;
	logic           wake_force;

	always_comb begin
		sx  = upp_pkg::sx_class(item.sys_state);
		row = {~item.charge_enable, ~item.ac_power};

		// debug level clamps to 100
		if (cfg.dbg_override) begin
			lvl = (cfg.dbg_level > upp_pkg::BATT_MAX) ? {1'b0, upp_pkg::BATT_MAX}
			                                          : {1'b0, cfg.dbg_level};
		end else begin
			lvl = item.battery_level;
		end
		band = upp_pkg::batt_band(lvl);

		aou_pol   = upp_pkg::aou_tab(row, sx);
		plain_pol = upp_pkg::plain_tab(row, sx);
		if (!item.ac_power && item.charge_enable) begin
			aou_pol = upp_pkg::aou_bat(sx, band);
			if (!item.s45_dc_allow && sx == upp_pkg::SX_S45) aou_pol = upp_pkg::MODE_OFF;
			plain_pol = upp_pkg::plain_bat(sx, band);
		end

		power_type = {1'b0, aou_pol, 1'b0, plain_pol};

		wake_force = item.bios_wake_disable && item.sys_state == upp_pkg::ST_S3 &&
		             !item.charge_enable;

		ctl.wake_force = wake_force;
		if (item.thermal_shutdown || wake_force) begin
			ctl.aou   = upp_pkg::MODE_OFF;
			ctl.plain = upp_pkg::MODE_OFF;
		end else begin
			ctl.aou   = aou_pol;
			ctl.plain = plain_pol;
		end
	end

endmodule

@@ rtl/upp_pin_state.sv @@
// ----------------------------------------------------------------------------
// upp_pin_state
// change-detected pin latches, last modes and s3 detect debounce
// ----------------------------------------------------------------------------
module upp_pin_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  upp_pkg::item_t     item,
	input  upp_pkg::mode_ctl_t ctl,
	input  logic [7:0]         db_reload,
	output logic [3:0]         pins_nxt,
	output logic               device_flag_nxt
);

	upp_pkg::mode_t last_aou_q;
	upp_pkg::mode_t last_plain_q;
	logic [7:0]     debounce_q;
	logic [3:0]     pins_q;
	logic [7:0]     debounce_nxt;
	logic           in_s3;

	// pins: bit0 charge, bit1 ctl1, bit2 ctl3, bit3 plain drive
	always_comb begin
		pins_nxt = pins_q;
		if (ctl.aou != last_aou_q) begin
			unique case (ctl.aou)
				upp_pkg::MODE_OFF: pins_nxt = {pins_q[3], 3'b000};
				upp_pkg::MODE_SDP: pins_nxt = {pins_q[3], 3'b011};
				upp_pkg::MODE_CDP: pins_nxt = {pins_q[3], 3'b111};
				upp_pkg::MODE_DCP: pins_nxt = {pins_q[3], 3'b101};
				default:           pins_nxt = pins_q;
			endcase
		end
		if (ctl.plain != last_plain_q) begin
			if (ctl.plain == upp_pkg::MODE_OFF) pins_nxt[3] = 1'b0;
			else if (ctl.plain != upp_pkg::MODE_ON) pins_nxt[3] = 1'b1;
			if (ctl.wake_force) pins_nxt[3] = 1'b0;
		end
	end

	// debounce: reload on detect in s3 with an empty count, hold flag while counting
	always_comb begin
		in_s3 = item.sys_state == upp_pkg::ST_S3 || item.sys_state == upp_pkg::ST_S0_TO_S3;
		debounce_nxt    = debounce_q;
		device_flag_nxt = 1'b1;
		if (item.detect_level) begin
			if (in_s3 && debounce_q == 8'd0) begin
				debounce_nxt = db_reload;
			end else if (debounce_q != 8'd0) begin
				debounce_nxt = debounce_q - 8'd1;
			end else begin
				device_flag_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_aou_q   <= upp_pkg::MODE_OFF;
			last_plain_q <= upp_pkg::MODE_OFF;
			debounce_q   <= 8'd0;
			pins_q       <= 4'd0;
		end else if (advance) begin
			last_aou_q   <= ctl.aou;
			last_plain_q <= ctl.plain;
			debounce_q   <= debounce_nxt;
			pins_q       <= pins_nxt;
		end
	end

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(pins_q) && $stable(debounce_q) && $stable(last_aou_q))
		else $error("pin state moved without an item");

	a_dcp_pins: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.aou == upp_pkg::MODE_DCP && last_aou_q != upp_pkg::MODE_DCP
		|=> pins_q[2:0] == 3'b101)
		else $error("dcp change did not set charger pins");

	a_debounce_dec: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.detect_level && debounce_q != 8'd0
		|=> debounce_q == 8'($past(debounce_q) - 8'd1))
		else $error("debounce count did not step down");

	a_wake_release: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl.wake_force && ctl.plain != last_plain_q |=> !pins_q[3])
		else $error("wake override left plain port driven");

endmodule

@@ rtl/usb_port_power_policy_top.sv @@
// ----------------------------------------------------------------------------
// usb_port_power_policy_top
// per-tick power policy for an always-on and an ordinary usb port
// ----------------------------------------------------------------------------
//  channel   dir   handshake                   payload
//  s_axis    in    s_axis_tvalid/tready        tdata: policy tick inputs
//  m_axis    out   m_axis_tvalid/tready        tdata: port modes, pins, flag
//  cfg       in    cfg_wr_en                   cfg_index, cfg_wdata
//
//  one transaction per cycle sustained while m_axis is ready; a tick is held in
//  the input register and its result is registered into the result register
//  that drives m_axis; table lookup and pin state update are combinational
//  reset (arst_n low) clears modes, pin latches, debounce count and valids;
//  debounce_reload resets to 40
//  a stalled m_axis holds the result register; s_axis keeps accepting until
//  the input register is also full
// ----------------------------------------------------------------------------
module usb_port_power_policy_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// sys_state[3:0] ac_power[4] charge_enable[5] s45_dc_allow[6]
	// battery_level[14:7] thermal_shutdown[15] bios_wake_disable[16]
	// detect_level[17] zero[23:18]
	input  logic [23:0] s_axis_tdata,

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// aou_mode[2:0] plain_mode[5:3] power_type_byte[13:6] aou_charge_pin[14]
	// ctl1_pin[15] ctl3_pin[16] plain_power_drive[17] device_flag[18]
	// zero[23:19]
	output logic [23:0] m_axis_tdata,

	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_wdata
);

	// configuration registers
	upp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dbg_override <= 1'b0;
			cfg_q.dbg_level    <= 7'd0;
			cfg_q.db_reload    <= upp_pkg::DB_RELOAD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				upp_pkg::CFG_DBG_OVERRIDE: cfg_q.dbg_override <= cfg_wdata[0];
				upp_pkg::CFG_DBG_LEVEL:    cfg_q.dbg_level    <= cfg_wdata[6:0];
				upp_pkg::CFG_DB_RELOAD:    cfg_q.db_reload    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	upp_pkg::item_t item_s1;
	logic           valid_s1;
	logic           advance;
	logic           accept;
	logic           out_valid_q;
	upp_pkg::result_t result_q;

	// move the held tick into the result register when that is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= upp_pkg::item_t'(s_axis_tdata[upp_pkg::ITEM_W-1:0]);
		end
	end

	// policy lookup and pin state
	upp_pkg::mode_ctl_t mode_ctl;
	logic [7:0]         power_type;
	logic [3:0]         pins_nxt;
	logic               device_flag_nxt;

	upp_mode_sel u_mode_sel (
		.item       (item_s1),
		.cfg        (cfg_q),
		.ctl        (mode_ctl),
		.power_type (power_type)
	);

	upp_pin_state u_pin_state (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item            (item_s1),
		.ctl             (mode_ctl),
		.db_reload       (cfg_q.db_reload),
		.pins_nxt        (pins_nxt),
		.device_flag_nxt (device_flag_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.aou_mode          <= mode_ctl.aou;
			result_q.plain_mode        <= mode_ctl.plain;
			result_q.power_type_byte   <= power_type;
			result_q.aou_charge_pin    <= pins_nxt[0];
			result_q.ctl1_pin          <= pins_nxt[1];
			result_q.ctl3_pin          <= pins_nxt[2];
			result_q.plain_power_drive <= pins_nxt[3];
			result_q.device_flag       <= device_flag_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(upp_pkg::TDATA_OUT_W - upp_pkg::RESULT_W){1'b0}}, result_q};

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_axis_tready |=> out_valid_q && $stable(result_q))
		else $error("result register overwritten while stalled");

	a_stage_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken with both stages full");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced tick did not reach the output");

endmodule

@@ bench/usb_port_power_policy_top_tb.sv @@
// ----------------------------------------------------------------------------
// usb_port_power_policy_top_tb
// self-checking bench for the usb port power policy block: a queue-fed driver
// pushes policy ticks into s_axis while a tick-level model of the mode tables,
// battery bands, overrides, pin latches and debounce counter predicts every
// m_axis result, which the monitor compares field by field
// ----------------------------------------------------------------------------
module usb_port_power_policy_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// sleep state codes the package does not name
	localparam logic [3:0] ST_S0       = 4'd0;
	localparam logic [3:0] ST_S5       = 4'd4;
	localparam logic [3:0] ST_UNLISTED = 4'd9;
	localparam logic [3:0] ST_TOP      = 4'd15;

	localparam int STALL_LIMIT   = 2000;
	localparam int TICKS_PER_SET = 140;
	localparam int NUM_SETS      = 6;

	// ------------------------------------------------------------------------
	// clock, reset and block inputs, all known from time zero
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [upp_pkg::TDATA_IN_W-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [upp_pkg::TDATA_OUT_W-1:0] m_axis_tdata;
	logic                            cfg_wr_en = 1'b0;
	logic [1:0]                      cfg_index = upp_pkg::CFG_DBG_OVERRIDE;
	logic [7:0]                      cfg_wdata = '0;

	always #10 clk = ~clk;

	usb_port_power_policy_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	// ------------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------------
	upp_pkg::item_t   tick_q[$];       // ticks waiting for the driver
	upp_pkg::result_t port_state_q[$]; // predicted results, oldest first
	int      mismatches = 0;
	int      cyc = 0;
	int      quiet_cycles = 0;

	// policy model copy of the registers and the state
	upp_pkg::cfg_t  policy_cfg;
	upp_pkg::mode_t prev_aou, prev_plain;
	logic [7:0]     hold_count;
	logic [3:0]     pin_q;     // bit0 charge, bit1 ctl1, bit2 ctl3, bit3 plain drive
	logic           present_q;

	// mode tables, [row][sleep class]; row 0 ac en, 1 dc en, 2 ac dis, 3 dc dis
	upp_pkg::mode_t aou_by_row [4][3] = '{
		'{upp_pkg::MODE_CDP, upp_pkg::MODE_DCP, upp_pkg::MODE_DCP},
		'{upp_pkg::MODE_CDP, upp_pkg::MODE_DCP, upp_pkg::MODE_OFF},
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_OFF},
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_OFF}};
	upp_pkg::mode_t plain_by_row [4][3] = '{
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_ON},
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_OFF},
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_OFF},
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_OFF}};
	// battery tables on dc with charging, [sleep class][band]
	upp_pkg::mode_t aou_by_band [3][4] = '{
		'{upp_pkg::MODE_CDP, upp_pkg::MODE_CDP, upp_pkg::MODE_CDP, upp_pkg::MODE_CDP},
		'{upp_pkg::MODE_DCP, upp_pkg::MODE_DCP, upp_pkg::MODE_SDP, upp_pkg::MODE_OFF},
		'{upp_pkg::MODE_DCP, upp_pkg::MODE_DCP, upp_pkg::MODE_OFF, upp_pkg::MODE_OFF}};
	upp_pkg::mode_t plain_by_band [3][4] = '{
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_SDP},
		'{upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_SDP, upp_pkg::MODE_OFF},
		'{upp_pkg::MODE_OFF, upp_pkg::MODE_OFF, upp_pkg::MODE_OFF, upp_pkg::MODE_OFF}};

	// register settings of the random sets, extremes included
	upp_pkg::cfg_t policy_sets [NUM_SETS] = '{
		'{1'b0, 7'd0,   8'd40},
		'{1'b1, 7'd127, 8'd0},    // debug level above 100, zero reload
		'{1'b1, 7'd0,   8'd255},
		'{1'b1, 7'd11,  8'd1},
		'{1'b1, 7'd100, 8'd5},
		'{1'b0, 7'd6,   8'd2}};

	// ------------------------------------------------------------------------
	// policy model: one tick in, the port state it leaves behind out
	// ------------------------------------------------------------------------
	function automatic upp_pkg::result_t predict_port_state(input upp_pkg::item_t t);
		upp_pkg::sx_t     sx;
		logic [1:0]       row, band;
		logic [7:0]       lvl, ptype;
		upp_pkg::mode_t   aou, plain;
		logic             wake_force;
		upp_pkg::result_t r;

		if (t.sys_state == upp_pkg::ST_S3 || t.sys_state == upp_pkg::ST_S0_TO_S3)
			sx = upp_pkg::SX_S3;
		else if (t.sys_state >= upp_pkg::ST_S4 && t.sys_state <= upp_pkg::ST_S5_TO_DSX)
			sx = upp_pkg::SX_S45;
		else
			sx = upp_pkg::SX_S0;  // unlisted codes count as s0

		// debounce: reload on detect in s3 with an empty count, else run down
		if (t.detect_level) begin
			present_q = 1'b0;
			if (sx == upp_pkg::SX_S3 && hold_count == 8'd0) begin
				hold_count = policy_cfg.db_reload;
				present_q = 1'b1;
			end else if (hold_count != 8'd0) begin
				hold_count = hold_count - 8'd1;
				present_q = 1'b1;
			end
		end else begin
			present_q = 1'b1;
		end

		row = {~t.charge_enable, ~t.ac_power};
		aou = aou_by_row[row][sx];
		plain = plain_by_row[row][sx];

		// dc with charging: battery band decides
		if (!t.ac_power && t.charge_enable) begin
			lvl = t.battery_level;
			if (policy_cfg.dbg_override)
				lvl = (policy_cfg.dbg_level > upp_pkg::BATT_MAX) ? 8'(upp_pkg::BATT_MAX)
					: 8'(policy_cfg.dbg_level);
			if (lvl <= 8'd5) band = 2'd3;
			else if (lvl <= 8'd10) band = 2'd2;
			else if (lvl <= 8'd15) band = 2'd1;
			else band = 2'd0;
			aou = aou_by_band[sx][band];
			if (!t.s45_dc_allow && sx == upp_pkg::SX_S45) aou = upp_pkg::MODE_OFF;
			plain = plain_by_band[sx][band];
		end
		ptype = {1'b0, aou, 4'b0000} + {5'b00000, plain};

		// overrides act after the status byte is formed
		wake_force = t.bios_wake_disable && t.sys_state == upp_pkg::ST_S3 &&
			!t.charge_enable;
		if (t.thermal_shutdown || wake_force) begin
			aou = upp_pkg::MODE_OFF;
			plain = upp_pkg::MODE_OFF;
		end

		// pins move only on a mode change
		if (aou != prev_aou) begin
			case (aou)
				upp_pkg::MODE_OFF: pin_q[2:0] = 3'b000;
				upp_pkg::MODE_SDP: pin_q[2:0] = 3'b011;
				upp_pkg::MODE_CDP: pin_q[2:0] = 3'b111;
				upp_pkg::MODE_DCP: pin_q[2:0] = 3'b101;
				default:           ;
			endcase
		end
		if (plain != prev_plain) begin
			if (plain == upp_pkg::MODE_OFF) pin_q[3] = 1'b0;
			else if (plain != upp_pkg::MODE_ON) pin_q[3] = 1'b1;
			if (wake_force) pin_q[3] = 1'b0;
		end
		prev_aou = aou;
		prev_plain = plain;

		r.aou_mode = aou;
		r.plain_mode = plain;
		r.power_type_byte = ptype;
		r.aou_charge_pin = pin_q[0];
		r.ctl1_pin = pin_q[1];
		r.ctl3_pin = pin_q[2];
		r.plain_power_drive = pin_q[3];
		r.device_flag = present_q;
		return r;
	endfunction

	// random backpressure and gaps, with a calm stretch in the middle
	function automatic bit idle_roll();
		return (cyc < 400 || cyc >= 650) && ($urandom_range(99) < 17);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// driver: one tick per free slot, taken from tick_q
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			// accepted transaction: predict its result right away
			if (s_axis_tvalid && s_axis_tready)
				port_state_q.push_back(predict_port_state(
					upp_pkg::item_t'(s_axis_tdata[upp_pkg::ITEM_W-1:0])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tick_q.size() != 0 && !idle_roll()) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= upp_pkg::TDATA_IN_W'(tick_q.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: random stalls, compare each result with the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !idle_roll();
			if (m_axis_tvalid && m_axis_tready) begin
				if (port_state_q.size() == 0) begin
					$display("%0t unexpected result: expected none actual %0h", $time,
						m_axis_tdata);
					mismatches++;
				end else begin
					upp_pkg::result_t want, got;
					want = port_state_q.pop_front();
					got = upp_pkg::result_t'(m_axis_tdata[upp_pkg::RESULT_W-1:0]);
					check_field("aou_mode", want.aou_mode, got.aou_mode);
					check_field("plain_mode", want.plain_mode, got.plain_mode);
					check_field("power_type_byte", want.power_type_byte, got.power_type_byte);
					check_field("aou_charge_pin", want.aou_charge_pin, got.aou_charge_pin);
					check_field("ctl1_pin", want.ctl1_pin, got.ctl1_pin);
					check_field("ctl3_pin", want.ctl3_pin, got.ctl3_pin);
					check_field("plain_power_drive", want.plain_power_drive,
						got.plain_power_drive);
					check_field("device_flag", want.device_flag, got.device_flag);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long without any transaction ends the run
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic upp_pkg::item_t mk_tick(input logic [3:0] st, input bit ac,
			input bit chg, input bit s45, input logic [7:0] batt, input bit therm,
			input bit wake, input bit det);
		upp_pkg::item_t t;
		t.sys_state = st;
		t.ac_power = ac;
		t.charge_enable = chg;
		t.s45_dc_allow = s45;
		t.battery_level = batt;
		t.thermal_shutdown = therm;
		t.bios_wake_disable = wake;
		t.detect_level = det;
		return t;
	endfunction

	// random tick; s3 weighted and detect held in runs so the debounce counter
	// gets reloaded and run down, battery often near the band edges
	function automatic upp_pkg::item_t random_tick(inout bit det_run);
		upp_pkg::item_t t;
		if ($urandom_range(99) < 20) det_run = ~det_run;
		t.sys_state = ($urandom_range(99) < 40) ? 4'($urandom_range(1, 2))
			: 4'($urandom_range(15));
		t.ac_power = 1'($urandom_range(1));
		t.charge_enable = ($urandom_range(99) < 65);
		t.s45_dc_allow = 1'($urandom_range(1));
		t.battery_level = $urandom_range(1) ? 8'($urandom_range(20)) : 8'($urandom_range(255));
		t.thermal_shutdown = ($urandom_range(99) < 10);
		t.bios_wake_disable = 1'($urandom_range(1));
		t.detect_level = det_run;
		return t;
	endfunction

	// registers are written back to back while the block is idle
	task automatic write_policy_regs(input upp_pkg::cfg_t c);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= upp_pkg::CFG_DBG_OVERRIDE;
		cfg_wdata <= {7'b0, c.dbg_override};
		@(posedge clk);
		cfg_index <= upp_pkg::CFG_DBG_LEVEL;
		cfg_wdata <= {1'b0, c.dbg_level};
		@(posedge clk);
		cfg_index <= upp_pkg::CFG_DB_RELOAD;
		cfg_wdata <= c.db_reload;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		policy_cfg = c;
	endtask

	// everything sent and every result back, checked on the falling edge
	task automatic wait_drained();
		do @(negedge clk);
		while (tick_q.size() != 0 || s_axis_tvalid || port_state_q.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		bit det_run;

		det_run = 1'b0;
		policy_cfg = '{1'b0, 7'd0, upp_pkg::DB_RELOAD_RST};
		prev_aou = upp_pkg::MODE_OFF;
		prev_plain = upp_pkg::MODE_OFF;
		hold_count = '0;
		pin_q = '0;
		present_q = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: short reload so the count empties and reloads
		write_policy_regs('{1'b0, 7'd0, 8'd3});
		tick_q.push_back(mk_tick(ST_S0,                1, 1, 1, 8'd50,  0, 0, 0));
		tick_q.push_back(mk_tick(ST_S0,                0, 1, 1, 8'd0,   0, 0, 1));
		// s3 on dc walking down the battery bands, detect held then released
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 1, 1, 8'd255, 0, 0, 1));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 1, 1, 8'd16,  0, 0, 1));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 1, 1, 8'd15,  0, 0, 1));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 1, 1, 8'd11,  0, 0, 1));
		tick_q.push_back(mk_tick(upp_pkg::ST_S0_TO_S3, 0, 1, 1, 8'd10,  0, 0, 1));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 1, 1, 8'd6,   0, 0, 1));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 1, 1, 8'd5,   0, 0, 0));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 1, 1, 8'd0,   0, 0, 0));
		// s4/s5 with charging, on ac and on dc: on ac the ordinary port goes to plain on
		tick_q.push_back(mk_tick(upp_pkg::ST_S4,       1, 1, 1, 8'd80,  0, 0, 0));
		tick_q.push_back(mk_tick(ST_S5,                0, 1, 0, 8'd100, 0, 0, 0));
		tick_q.push_back(mk_tick(ST_S5,                0, 1, 1, 8'd100, 0, 0, 0));
		tick_q.push_back(mk_tick(upp_pkg::ST_S5_TO_DSX, 1, 1, 1, 8'd3,  0, 0, 1));
		// wake device in s3 with charging off forces both ports off; s0 to s3 does not
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       1, 0, 1, 8'd50,  0, 1, 0));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       0, 0, 0, 8'd50,  0, 1, 1));
		tick_q.push_back(mk_tick(upp_pkg::ST_S0_TO_S3, 1, 0, 1, 8'd50,  0, 1, 0));
		tick_q.push_back(mk_tick(ST_S0,                1, 1, 1, 8'd50,  1, 0, 0));
		// unlisted sleep codes behave as s0, mixed with s4, s0 and s3 ticks
		tick_q.push_back(mk_tick(ST_TOP,               1, 0, 1, 8'd50,  0, 0, 1));
		tick_q.push_back(mk_tick(ST_UNLISTED,          0, 0, 1, 8'd20,  0, 0, 0));
		tick_q.push_back(mk_tick(upp_pkg::ST_S4,       0, 0, 1, 8'd20,  0, 0, 0));
		tick_q.push_back(mk_tick(ST_TOP,               1, 1, 1, 8'd255, 1, 1, 1));
		tick_q.push_back(mk_tick(ST_S0,                0, 0, 0, 8'd0,   0, 0, 0));
		tick_q.push_back(mk_tick(upp_pkg::ST_S3,       1, 1, 1, 8'd128, 0, 0, 0));
		wait_drained();

		// random sets, one register setting each
		for (int s = 0; s < NUM_SETS; s++) begin
			write_policy_regs(policy_sets[s]);
			for (int n = 0; n < TICKS_PER_SET; n++)
				tick_q.push_back(random_tick(det_run));
			wait_drained();
		end

		// let any stray result show up before the verdict
		repeat (10) @(posedge clk);
		if (port_state_q.size() != 0) begin
			$display("%0t results missing: expected %0d more actual 0", $time,
				port_state_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
